[rtl/pts_pkg.sv]
// Shared types and codes of the periodic task scheduler.
package pts_pkg;

    // Field widths fixed by the item format
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Most due slots reported by one run-pending walk
    localparam int RESULT_CAP = 16;
    localparam int NDUE_W     = 5;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_SET    = 2'd1,
        OP_RUN    = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED      = 3'd0,
        ST_REJECTED   = 3'd1,
        ST_ENABLE_SET = 3'd2,
        ST_DUE        = 3'd3,
        ST_NONE_DUE   = 3'd4
    } status_t;

endpackage

[rtl/periodic_task_scheduler_core.sv]
// Periodic task scheduler: slot table, walk sequencer and shared serial remainder unit.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------------------
//   command  | in        | start high, busy low   | op, now_ms, period, first_delay, slot_id,
//            |           |                        | enable_flag
//   result   | out       | result_valid, 1 cycle  | status, result_slot, slot_count, last
//
// Add, a rejected command and run-pending with no slots give their result in the
// cycle after acceptance and leave busy low. Set-enable holds busy for one table read.
// Run-pending reads and checks each added slot in turn (S_RD, S_CHK); a due slot also
// passes through the bit-serial remainder unit (S_DIV) and a deadline update (S_UPD). The
// walk stops after RESULT_CAP due slots and ends in S_END. Reset clears the enable bits, the
// slot count and the sequencer; the table memories need no clearing. Results cannot be stalled.
module periodic_task_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pts_pkg::OP_W-1:0]      op,
    input  logic [pts_pkg::TIME_W-1:0]    now_ms,
    input  logic [pts_pkg::TIME_W-1:0]    period,
    input  logic [pts_pkg::TIME_W-1:0]    first_delay,
    input  logic [pts_pkg::SLOT_W-1:0]    slot_id,
    input  logic                          enable_flag,
    output logic                          result_valid,
    output logic [pts_pkg::STATUS_W-1:0]  status,
    output logic [pts_pkg::SLOT_W-1:0]    result_slot,
    output logic [pts_pkg::COUNT_W-1:0]   slot_count,
    output logic                          last
);

    localparam int TW  = pts_pkg::TIME_W;
    localparam int IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW  = $clog2(MAX_TASKS + 1);
    localparam int XW  = (IW > pts_pkg::SLOT_W) ? IW : pts_pkg::SLOT_W;
    localparam int KW  = (CW > pts_pkg::SLOT_W) ? CW : pts_pkg::SLOT_W;
    localparam int EW  = (CW > pts_pkg::COUNT_W) ? CW : pts_pkg::COUNT_W;
    localparam int BW  = $clog2(TW);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SET  = 7'b0000010,
        S_RD   = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_UPD  = 7'b0100000,
        S_END  = 7'b1000000
    } state_t;

    // Slot table memories
    logic [TW-1:0] period_mem   [MAX_TASKS];
    logic [TW-1:0] deadline_mem [MAX_TASKS];

    // Control state
    state_t                 state_reg, state_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [MAX_TASKS-1:0]   en_bits_reg, en_bits_next;
    logic [pts_pkg::NDUE_W-1:0] ndue_reg, ndue_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [BW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic                   result_valid_reg, result_valid_next;

    // Payload state
    logic [TW-1:0]          now_reg, now_next;
    logic [IW-1:0]          sid_reg, sid_next;
    logic                   en_reg, en_next;
    logic [IW-1:0]          pend_slot_reg, pend_slot_next;
    logic [TW-1:0]          rem_reg, rem_next;
    logic [TW-1:0]          dvd_reg, dvd_next;
    logic [TW-1:0]          rd_per_reg, rd_dl_reg;
    logic [pts_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [pts_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic                   last_reg, last_next;

    // Memory port controls
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic                   per_we, dl_we;
    logic [IW-1:0]          wr_addr;
    logic [TW-1:0]          dl_wd;

    // Helpers
    logic                   accept;
    logic [XW-1:0]          sid_x, pend_x, cidx_x;
    logic [KW-1:0]          sid_k, count_k;
    logic [EW-1:0]          count_e;
    logic [IW-1:0]          sid_idx, cidx;
    logic [TW-1:0]          elapsed;
    logic [TW:0]            trial, trial_sub;
    logic                   trial_ge;
    logic [CW:0]            idx_inc, count_w;
    logic                   last_slot;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);

    assign sid_x   = XW'(slot_id);
    assign sid_idx = sid_x[IW-1:0];
    assign sid_k   = KW'(slot_id);
    assign count_k = KW'(count_reg);
    assign cidx_x  = XW'(count_reg);
    assign cidx    = cidx_x[IW-1:0];
    assign pend_x  = XW'(pend_slot_reg);
    assign count_e = EW'(count_reg);

    // Walk bookkeeping: is the current slot the last added one
    assign idx_inc   = (CW + 1)'(idx_reg) + (CW + 1)'(1);
    assign count_w   = (CW + 1)'(count_reg);
    assign last_slot = (idx_inc >= count_w);

    // Wrap-aware lateness of the slot just read
    assign elapsed = now_reg - rd_dl_reg;

    // Restoring remainder step: shift in one dividend bit, subtract when it fits
    assign trial     = {rem_reg, dvd_reg[TW-1]};
    assign trial_sub = trial - {1'b0, rd_per_reg};
    assign trial_ge  = (trial >= {1'b0, rd_per_reg});

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        en_bits_next      = en_bits_reg;
        ndue_next         = ndue_reg;
        pend_valid_next   = pend_valid_reg;
        bit_cnt_next      = bit_cnt_reg;
        now_next          = now_reg;
        sid_next          = sid_reg;
        en_next           = en_reg;
        pend_slot_next    = pend_slot_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        result_valid_next = 1'b0;
        status_next       = status_reg;
        slot_next         = slot_reg;
        last_next         = last_reg;
        rd_en             = 1'b0;
        rd_addr           = idx_reg;
        per_we            = 1'b0;
        dl_we             = 1'b0;
        wr_addr           = idx_reg;
        dl_wd             = now_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        pts_pkg::OP_ADD:
                        begin
                            result_valid_next = 1'b1;
                            last_next         = 1'b1;
                            if ((period != '0) && (count_reg < CW'(MAX_TASKS)))
                            begin
                                per_we                = 1'b1;
                                dl_we                 = 1'b1;
                                wr_addr               = cidx;
                                dl_wd                 = now_ms + first_delay;
                                en_bits_next[cidx]    = 1'b1;
                                count_next            = count_reg + CW'(1);
                                status_next           = pts_pkg::ST_ADDED;
                                slot_next             = cidx_x[pts_pkg::SLOT_W-1:0];
                            end
                            else
                            begin
                                status_next = pts_pkg::ST_REJECTED;
                                slot_next   = '0;
                            end
                        end
                        pts_pkg::OP_SET:
                        begin
                            if (sid_k < count_k)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = sid_idx;
                                sid_next   = sid_idx;
                                en_next    = enable_flag;
                                now_next   = now_ms;
                                state_next = S_SET;
                            end
                            else
                            begin
                                result_valid_next = 1'b1;
                                status_next       = pts_pkg::ST_REJECTED;
                                slot_next         = '0;
                                last_next         = 1'b1;
                            end
                        end
                        pts_pkg::OP_RUN:
                        begin
                            if (count_reg == '0)
                            begin
                                result_valid_next = 1'b1;
                                status_next       = pts_pkg::ST_NONE_DUE;
                                slot_next         = '0;
                                last_next         = 1'b1;
                            end
                            else
                            begin
                                rd_en           = 1'b1;
                                rd_addr         = '0;
                                idx_next        = '0;
                                ndue_next       = '0;
                                pend_valid_next = 1'b0;
                                now_next        = now_ms;
                                state_next      = S_CHK;
                            end
                        end
                        default:
                        begin
                            result_valid_next = 1'b1;
                            status_next       = pts_pkg::ST_REJECTED;
                            slot_next         = '0;
                            last_next         = 1'b1;
                        end
                    endcase
                end
            end

            // Re-arm a slot that turns on, then store the new flag
            S_SET:
            begin
                if (en_reg && !en_bits_reg[sid_reg])
                begin
                    dl_we   = 1'b1;
                    wr_addr = sid_reg;
                    dl_wd   = now_reg + rd_per_reg;
                end
                en_bits_next[sid_reg] = en_reg;
                result_valid_next     = 1'b1;
                status_next           = pts_pkg::ST_ENABLE_SET;
                slot_next             = '0;
                last_next             = 1'b1;
                state_next            = S_IDLE;
            end

            // Fetch the current slot
            S_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_CHK;
            end

            // Start the remainder for a due slot, else advance
            S_CHK:
            begin
                if (en_bits_reg[idx_reg] && !elapsed[TW-1])
                begin
                    rem_next     = '0;
                    dvd_next     = elapsed;
                    bit_cnt_next = '0;
                    state_next   = S_DIV;
                end
                else if (last_slot)
                begin
                    state_next = S_END;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_RD;
                end
            end

            // One remainder bit per cycle
            S_DIV:
            begin
                rem_next     = trial_ge ? trial_sub[TW-1:0] : trial[TW-1:0];
                dvd_next     = {dvd_reg[TW-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BW'(1);
                if (bit_cnt_reg == BW'(TW - 1))
                begin
                    state_next = S_UPD;
                end
            end

            // Skip missed periods: new deadline is now - (elapsed mod period) + period
            S_UPD:
            begin
                dl_we   = 1'b1;
                wr_addr = idx_reg;
                dl_wd   = now_reg - rem_reg + rd_per_reg;
                if (pend_valid_reg)
                begin
                    result_valid_next = 1'b1;
                    status_next       = pts_pkg::ST_DUE;
                    slot_next         = pend_x[pts_pkg::SLOT_W-1:0];
                    last_next         = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_slot_next  = idx_reg;
                ndue_next       = ndue_reg + pts_pkg::NDUE_W'(1);
                if (last_slot || (ndue_reg == pts_pkg::NDUE_W'(pts_pkg::RESULT_CAP - 1)))
                begin
                    state_next = S_END;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_RD;
                end
            end

            // Flush the held due slot as the final result, or report none due
            S_END:
            begin
                result_valid_next = 1'b1;
                last_next         = 1'b1;
                if (pend_valid_reg)
                begin
                    status_next = pts_pkg::ST_DUE;
                    slot_next   = pend_x[pts_pkg::SLOT_W-1:0];
                end
                else
                begin
                    status_next = pts_pkg::ST_NONE_DUE;
                    slot_next   = '0;
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            count_reg        <= '0;
            en_bits_reg      <= '0;
            ndue_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            bit_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            count_reg        <= count_next;
            en_bits_reg      <= en_bits_next;
            ndue_reg         <= ndue_next;
            pend_valid_reg   <= pend_valid_next;
            bit_cnt_reg      <= bit_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        sid_reg       <= sid_next;
        en_reg        <= en_next;
        pend_slot_reg <= pend_slot_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        last_reg      <= last_next;
    end

    // Table memories: one write port each, registered read
    always_ff @(posedge clk)
    begin
        if (per_we)
        begin
            period_mem[wr_addr] <= period;
        end
        if (dl_we)
        begin
            deadline_mem[wr_addr] <= dl_wd;
        end
        if (rd_en)
        begin
            rd_per_reg <= period_mem[rd_addr];
            rd_dl_reg  <= deadline_mem[rd_addr];
        end
    end

    // Drive result ports
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign result_slot  = slot_reg;
    assign slot_count   = count_e[pts_pkg::COUNT_W-1:0];
    assign last         = last_reg;

endmodule

[rtl/pts_check.sv]
// Port-level checker for the periodic task scheduler, bound to the top level.
module pts_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [pts_pkg::OP_W-1:0]      op,
    input logic                          result_valid,
    input logic [pts_pkg::STATUS_W-1:0]  status,
    input logic [pts_pkg::SLOT_W-1:0]    result_slot,
    input logic                          last
);

    // Every status other than task due closes its item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != pts_pkg::ST_DUE) |-> last)
    else $error("single-result status without last");

    // A due slot that is not final leaves the walk running
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
    else $error("non-final result while idle");

    // Add and unused opcodes answer in the next cycle and close the item
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((op == pts_pkg::OP_ADD) || (op == pts_pkg::OP_UNUSED))
        |=> result_valid && last && !busy)
    else $error("add or unused opcode did not answer at once");

    // Only added and due results carry a slot id
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != pts_pkg::ST_ADDED) && (status != pts_pkg::ST_DUE)
        |-> (result_slot == '0))
    else $error("slot id on a result that carries none");

    // Set-enable either holds busy for its table read or answers at once
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op == pts_pkg::OP_SET) |=> (busy || result_valid))
    else $error("set-enable neither busy nor answered");

endmodule

bind periodic_task_scheduler_core pts_check u_pts_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .result_valid (result_valid),
    .status       (status),
    .result_slot  (result_slot),
    .last         (last)
);
